// ===== design/rqdf_pkg.sv =====
// Shared constants, command and status codes, and transaction layouts for the ring queue.
package rqdf_pkg;

    localparam int DEPTH          = 16;
    localparam int SLOT_W         = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int VALUE_W        = 32;
    localparam int CMD_W          = 3;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int IN_FIELDS_W  = VALUE_W + SLOT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VALUE_W + SLOT_W + 1 + 2 + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DROP  = 3'd3,
        CMD_FIND  = 3'd4,
        CMD_COUNT = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_SLOT = 2'd3
    } t_status;

    typedef struct packed {
        logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
        logic [SLOT_W-1:0]                 slot_index;
        logic [VALUE_W-1:0]                item_value;
    } t_in_item;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic                                queue_empty;
        logic [CNT_W-1:0]                    occupancy;
        t_status                             status;
        logic                                found;
        logic [SLOT_W-1:0]                   result_slot;
        logic [VALUE_W-1:0]                  result_value;
    } t_result;

    typedef struct packed {
        logic load;
        logic shift_dn;
        logic shift_up;
    } t_cell_ctrl;

endpackage

// ===== design/ring_queue_with_drop_and_find_core.sv =====
// Top level of the ring queue with push, pop, peek, drop by slot, find by value and count.
//
// Commands arrive on the s_axis channel: tuser carries the command code and tdata the
// pushed or searched word and the slot to drop. Every command transaction produces
// exactly one result transaction on the m_axis channel with the returned word, the
// matching slot, the found flag, a status code, the occupancy and the empty flag.
// The queue is a row of identical cells, one per physical slot. A drop closes the gap
// by moving one side of the queue by one cell: the tail side when the entries from the
// dropped slot to the tail do not wrap, else the head side. Find compares every cell
// at once and picks the first occupied match counted from the head. The result is
// registered and appears in the cycle after the command is accepted. A new command is
// taken in every cycle while the output register is empty or its result is taken in the
// same cycle, so the block sustains one command per cycle. When the receiver stalls, the
// result is held and s_axis_tready drops until it is taken. Reset empties the queue and
// clears the output valid flag; the stored words and the result fields are not cleared.
module ring_queue_with_drop_and_find_core #(
    parameter int DATA_WIDTH = rqdf_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // item_value, slot_index, zero pad
    input  logic [rqdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [rqdf_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_value, result_slot, found, status, occupancy, queue_empty, zero pad
    output logic [rqdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rqdf_pkg::*;

    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] n_head;
    logic [SLOT_W-1:0] n_tail;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_result           r_res;
    t_result           n_res;

    t_in_item              in_item;
    t_cmd                  cmd;
    logic                  accept;
    logic [SLOT_W-1:0]     last;
    logic [SLOT_W-1:0]     idx;
    logic                  full;
    logic                  empty;
    logic                  idx_occ;
    logic                  is_head;
    logic                  is_last;
    logic                  down_side;
    logic                  push_go;
    logic                  drop_go;
    logic                  drop_dn;
    logic                  drop_up;
    logic [SLOT_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] key;
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      occ;
    logic [DEPTH-1:0]      hit;
    logic [DEPTH-1:0]      hit_hi;
    logic [SLOT_W-1:0]     sel_lo;
    logic [SLOT_W-1:0]     sel_hi;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    t_cell_ctrl            cell_ctrl [DEPTH];

    assign in_item       = t_in_item'(s_axis_tdata);
    assign cmd           = t_cmd'(s_axis_tuser);
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key           = DATA_WIDTH'(in_item.item_value);
    assign idx           = in_item.slot_index;
    assign last          = r_tail - 1'b1;
    assign full          = (r_count == CNT_W'(DEPTH));
    assign empty         = (r_count == '0);
    assign idx_occ       = ({1'b0, SLOT_W'(idx - r_head)} < r_count);
    assign is_head       = (idx == r_head);
    assign is_last       = (idx == last);
    assign down_side     = (r_head < last) || (idx < last);
    assign drop_dn       = drop_go && !is_head && !is_last && down_side;
    assign drop_up       = drop_go && !is_head && !is_last && !down_side;
    assign rd_addr       = (cmd == CMD_DROP) ? idx : r_head;
    assign rd_data       = cell_data[rd_addr];

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        localparam int UP = (j + 1) % DEPTH;
        localparam int DN = (j + DEPTH - 1) % DEPTH;

        assign cell_ctrl[j].load     = accept && push_go && (r_tail == SLOT_W'(j));
        assign cell_ctrl[j].shift_dn = accept && drop_dn
                                       && (SLOT_W'(j) >= idx) && (SLOT_W'(j) < last);
        assign cell_ctrl[j].shift_up = accept && drop_up
                                       && (SLOT_W'(j) > r_head) && (SLOT_W'(j) <= idx);
        assign occ[j]    = ({1'b0, SLOT_W'(SLOT_W'(j) - r_head)} < r_count);
        assign hit_hi[j] = hit[j] && (SLOT_W'(j) >= r_head);

        rqdf_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[j]),
            .i_key   (key),
            .i_above (cell_data[UP]),
            .i_below (cell_data[DN]),
            .o_data  (cell_data[j]),
            .o_match (match[j])
        );
    end

    assign hit = match & occ;

    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (hit[j]) begin
                sel_lo = SLOT_W'(j);
            end
            if (hit_hi[j]) begin
                sel_hi = SLOT_W'(j);
            end
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        push_go = 1'b0;
        drop_go = 1'b0;
        n_res   = '0;
        n_res.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    push_go = 1'b1;
                    n_tail  = r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.result_value = VALUE_W'(rd_data);
                    if (cmd == CMD_POP) begin
                        n_head  = r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_DROP: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else if (!idx_occ) begin
                    n_res.status = ST_BAD_SLOT;
                end else begin
                    n_res.result_value = VALUE_W'(rd_data);
                    drop_go = 1'b1;
                    n_count = r_count - 1'b1;
                    if (is_head) begin
                        n_head = r_head + 1'b1;
                    end else if (is_last || down_side) begin
                        n_tail = r_tail - 1'b1;
                    end else begin
                        n_head = r_head + 1'b1;
                    end
                end
            end
            CMD_FIND: begin
                n_res.found       = |hit;
                n_res.result_slot = (|hit_hi) ? sel_hi : sel_lo;
            end
            default: begin
            end
        endcase
        n_res.occupancy   = n_count;
        n_res.queue_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_res;

endmodule

// ===== design/rqdf_cell.sv =====
// One queue storage cell: holds a word, loads it or takes it from a neighbor, compares it.
module rqdf_cell #(
    parameter int DATA_WIDTH = rqdf_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  rqdf_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_key,
    input  logic [DATA_WIDTH-1:0]  i_above,
    input  logic [DATA_WIDTH-1:0]  i_below,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_match
);
    import rqdf_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_key;
        end else if (i_ctrl.shift_dn) begin
            n_data = i_above;
        end else if (i_ctrl.shift_up) begin
            n_data = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

// ===== design/rqdf_chk.sv =====
// Port checker for the ring queue, attached to the top level by a bind statement.
module rqdf_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rqdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rqdf_pkg::*;

    t_result res;

    assign res = t_result'(m_axis_tdata);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.queue_empty == (res.occupancy == '0))
                          && (res.occupancy <= CNT_W'(DEPTH)))
        else $error("Occupancy and empty flag disagree.");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.found |-> res.status == ST_OK && res.result_value == '0
                                       && res.occupancy != '0)
        else $error("Find result carries other fields.");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input stalled without a pending result.");

endmodule

bind ring_queue_with_drop_and_find_core rqdf_chk u_rqdf_chk (.*);

// ===== tb/rqdf_result_check.sv =====
// Checker that predicts every ring queue result and compares it with the block's output.
`timescale 1ns / 1ps
module rqdf_result_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_tvalid,
    input  logic                             i_cmd_tready,
    input  logic [rqdf_pkg::IN_TDATA_W-1:0]  i_cmd_tdata,
    input  logic [rqdf_pkg::CMD_W-1:0]       i_cmd_tuser,
    input  logic                             i_res_tvalid,
    input  logic                             i_res_tready,
    input  logic [rqdf_pkg::OUT_TDATA_W-1:0] i_res_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_find_hits,
    output int                               o_inner_drops,
    output logic [3:0]                       o_status_seen
);
    import rqdf_pkg::*;

    logic [VALUE_W-1:0] cell_word [DEPTH];
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic [CNT_W-1:0]   stored;
    t_result            queued_results [$];
    int                 accepted;
    int                 retired;
    int                 fail_total;
    int                 find_hits;
    int                 inner_drops;
    logic [3:0]         status_seen;

    assign o_fail_count  = fail_total;
    assign o_pending     = accepted - retired;
    assign o_checked     = retired;
    assign o_find_hits   = find_hits;
    assign o_inner_drops = inner_drops;
    assign o_status_seen = status_seen;

    initial begin
        fail_total  = 0;
        find_hits   = 0;
        inner_drops = 0;
        status_seen = '0;
        accepted    = 0;
        retired     = 0;
    end

    task automatic apply_command(input t_cmd op, input logic [VALUE_W-1:0] word,
                                 input logic [SLOT_W-1:0] slot, output t_result res);
        logic [SLOT_W-1:0] last_slot;
        logic [SLOT_W-1:0] pos;
        int                j;
        res = '0;
        res.status = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (stored == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    cell_word[tail_slot] = word;
                    tail_slot++;
                    stored++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stored == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.result_value = cell_word[head_slot];
                    if (op == CMD_POP) begin
                        head_slot++;
                        stored--;
                    end
                end
            end
            CMD_DROP: begin
                pos = slot - head_slot;
                last_slot = tail_slot - 1'b1;
                if (stored == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= stored) begin
                    res.status = ST_BAD_SLOT;
                end else begin
                    res.result_value = cell_word[slot];
                    if (slot == head_slot) begin
                        head_slot++;
                    end else if (slot == last_slot) begin
                        tail_slot--;
                    end else if (head_slot < last_slot || slot < last_slot) begin
                        // The entries from the slot to the tail do not wrap: later entries close the gap downward.
                        for (j = int'(slot); j < last_slot; j++) begin
                            cell_word[j] = cell_word[j + 1];
                        end
                        tail_slot--;
                        inner_drops++;
                    end else begin
                        for (j = int'(slot); j > head_slot; j--) begin
                            cell_word[j] = cell_word[j - 1];
                        end
                        head_slot++;
                        inner_drops++;
                    end
                    stored--;
                end
            end
            CMD_FIND: begin
                for (j = 0; j < stored; j++) begin
                    pos = head_slot + SLOT_W'(j);
                    if (!res.found && cell_word[pos] == word) begin
                        res.result_slot = pos;
                        res.found = 1'b1;
                    end
                end
                if (res.found) begin
                    find_hits++;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = stored;
        res.queue_empty = (stored == 0);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want_v,
                               input logic [VALUE_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result  want;
        t_result  got;
        t_in_item cmd_item;
        if (!i_rst_n) begin
            head_slot = '0;
            tail_slot = '0;
            stored = '0;
            queued_results.delete();
            accepted <= 0;
            retired <= 0;
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                got = t_result'(i_res_tdata);
                if (queued_results.size() == 0) begin
                    $error("result transaction with no command outstanding: 0x%0h",
                           i_res_tdata);
                    fail_total++;
                end else begin
                    want = queued_results.pop_front();
                    retired <= retired + 1;
                    status_seen[want.status] = 1'b1;
                    check_field("result_value", want.result_value, got.result_value);
                    check_field("result_slot", VALUE_W'(want.result_slot),
                                VALUE_W'(got.result_slot));
                    check_field("found", VALUE_W'(want.found), VALUE_W'(got.found));
                    check_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
                    check_field("occupancy", VALUE_W'(want.occupancy),
                                VALUE_W'(got.occupancy));
                    check_field("queue_empty", VALUE_W'(want.queue_empty),
                                VALUE_W'(got.queue_empty));
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                cmd_item = t_in_item'(i_cmd_tdata);
                apply_command(t_cmd'(i_cmd_tuser), cmd_item.item_value,
                              cmd_item.slot_index, want);
                queued_results.push_back(want);
                accepted <= accepted + 1;
            end
        end
    end

endmodule

// ===== tb/tb_ring_queue_with_drop_and_find_core.sv =====
// Testbench top that drives commands into the ring queue and reports the verdict.
`timescale 1ns / 1ps
module tb_ring_queue_with_drop_and_find_core;
    import rqdf_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 165;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 find_hits;
    int                 inner_drops;
    logic [3:0]         status_seen;
    int                 sent_count;
    int                 cycle_count;
    bit                 calm;
    bit                 long_hold;
    logic [VALUE_W-1:0] word_pool [8];

    ring_queue_with_drop_and_find_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rqdf_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_tvalid  (s_axis_tvalid),
        .i_cmd_tready  (s_axis_tready),
        .i_cmd_tdata   (s_axis_tdata),
        .i_cmd_tuser   (s_axis_tuser),
        .i_res_tvalid  (m_axis_tvalid),
        .i_res_tready  (m_axis_tready),
        .i_res_tdata   (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_find_hits   (find_hits),
        .o_inner_drops (inner_drops),
        .o_status_seen (status_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[ring_queue_with_drop_and_find_core] ERROR");
        $finish;
    end

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_command(input t_cmd op, input logic [VALUE_W-1:0] word,
                                input logic [SLOT_W-1:0] slot);
        t_in_item pkt;
        int       gap;
        pkt = '0;
        pkt.item_value = word;
        pkt.slot_index = slot;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pkt;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        return $urandom_range(0, 1) ? word_pool[$urandom_range(0, 7)] : $urandom();
    endfunction

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (48) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int   k;
        int   phase;
        int   pick;
        int   push_weight;
        t_cmd op;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_COUNT;
        sent_count = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        word_pool[0] = '0;
        word_pool[1] = '1;
        for (k = 2; k < 8; k++) begin
            word_pool[k] = $urandom();
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Everything on an empty queue first.
        send_command(CMD_COUNT, '0, '0);
        send_command(CMD_POP, '0, '0);
        send_command(CMD_PEEK, '0, '0);
        send_command(CMD_DROP, '1, '0);
        send_command(CMD_FIND, '0, '0);
        for (k = 0; k < DEPTH; k++) begin
            send_command(CMD_PUSH, (k < 2) ? word_pool[k] : $urandom(), SLOT_W'(k));
        end
        send_command(CMD_PUSH, 32'h5A5A_A5A5, '0);
        send_command(CMD_FIND, '1, '0);
        send_command(CMD_DROP, '0, SLOT_W'(7));
        send_command(CMD_POP, '0, '0);
        send_command(CMD_DROP, '0, '1);
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 3);
            if (phase == 1) begin
                long_hold = 1'b1;
            end
            case (phase % 3)
                0: push_weight = 55;
                1: push_weight = 20;
                default: push_weight = 35;
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < push_weight) begin
                    op = CMD_PUSH;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: op = CMD_POP;
                        3:       op = CMD_PEEK;
                        4, 5, 6: op = CMD_DROP;
                        7, 8:    op = CMD_FIND;
                        default: op = CMD_COUNT;
                    endcase
                end
                send_command(op, pick_word(), SLOT_W'($urandom_range(0, DEPTH - 1)));
            end
            drain_results();
        end
        calm = 1'b0;
        repeat (4) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results; %0d finds hit an entry.",
                 sent_count, checked, find_hits);
        $display("%0d drops shifted entries inside the queue; status codes seen: %b.",
                 inner_drops, status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[ring_queue_with_drop_and_find_core] OK");
        end else begin
            $display("[ring_queue_with_drop_and_find_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rqdf_pkg.sv
design/rqdf_cell.sv
design/ring_queue_with_drop_and_find_core.sv
design/rqdf_chk.sv
tb/rqdf_result_check.sv
tb/tb_ring_queue_with_drop_and_find_core.sv
